### hw/rtl/wnm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wnm_pkg
// shared types and constants for the wildcard name matcher
// ----------------------------------------------------------------------------
package wnm_pkg;

    localparam int MAX_LEN_DEF = 32;

    localparam logic [7:0] ANY_ONE = 8'h3F;
    localparam logic [7:0] ANY_RUN = 8'h2A;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_SCAN,
        S_SCAN_EV,
        S_TAIL,
        S_TAIL_EV,
        S_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic init;
        logic fetch;
        logic scan_step;
        logic tail_step;
        logic res_set;
        logic res_match;
        logic res_ovf;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic ovf;
        logic n_done;
        logic p_done;
        logic scan_fail;
        logic tail_star;
        logic out_free;
    } status_t;

endpackage
`default_nettype wire

### hw/rtl/wildcard_name_matcher.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wildcard_name_matcher
// glob match of streamed names against a stored pattern with '?' and '*'
// ----------------------------------------------------------------------------
// requests: pattern and name characters are taken one request per cycle while
//   the sequencer is idle; item_stall holds them while a match is in progress.
//   A name's result follows its last request after S scan and T tail store
//   reads (up to about plen*nlen), each a registered store read and then an
//   evaluation step; an overflow result skips the match walk
// reset: lengths and overflow flags cleared, both strings closed, no result
// ----------------------------------------------------------------------------
module wildcard_name_matcher
    import wnm_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       item_valid,
    output logic            item_stall,
    input  wire logic       mode,
    input  wire logic [7:0] character,
    input  wire logic       has_char,
    input  wire logic       last,
    output logic            result_valid,
    input  wire logic       result_stall,
    output logic            matched,
    output logic            overflow
);

    cmd_t    cmd;
    status_t status;

    wnm_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .mode       (mode),
        .last       (last),
        .item_stall (item_stall),
        .status     (status),
        .cmd        (cmd)
    );

    wnm_dp #(
        .MAX_LEN (MAX_LEN)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .mode         (mode),
        .character    (character),
        .has_char     (has_char),
        .last         (last),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .matched      (matched),
        .overflow     (overflow)
    );

endmodule
`default_nettype wire

### hw/rtl/wnm_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wnm_ctrl
// sequencer for request intake and the star-backtracking match walk
// ----------------------------------------------------------------------------
module wnm_ctrl
    import wnm_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    item_valid,
    input  wire logic    mode,
    input  wire logic    last,
    output logic         item_stall,
    input  wire status_t status,
    output cmd_t         cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        item_stall = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                item_stall = 1'b0;
                if (item_valid)
                begin
                    cmd.load = 1'b1;
                    if (mode && last)
                    begin
                        state_next = S_INIT;
                    end
                end
            end
            S_INIT:
            begin
                cmd.init = 1'b1;
                if (status.ovf)
                begin
                    cmd.res_set = 1'b1;
                    cmd.res_ovf = 1'b1;
                    state_next  = S_DONE;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (status.n_done)
                begin
                    state_next = S_TAIL;
                end
                else
                begin
                    cmd.fetch  = 1'b1;
                    state_next = S_SCAN_EV;
                end
            end
            S_SCAN_EV:
            begin
                if (status.scan_fail)
                begin
                    cmd.res_set = 1'b1;
                    state_next  = S_DONE;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                    state_next    = S_SCAN;
                end
            end
            S_TAIL:
            begin
                if (status.p_done)
                begin
                    cmd.res_set   = 1'b1;
                    cmd.res_match = 1'b1;
                    state_next    = S_DONE;
                end
                else
                begin
                    cmd.fetch  = 1'b1;
                    state_next = S_TAIL_EV;
                end
            end
            S_TAIL_EV:
            begin
                if (status.tail_star)
                begin
                    cmd.tail_step = 1'b1;
                    state_next    = S_TAIL;
                end
                else
                begin
                    cmd.res_set = 1'b1;
                    state_next  = S_DONE;
                end
            end
            S_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

### hw/rtl/wnm_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wnm_dp
// pattern and name stores, match pointers and result register
// ----------------------------------------------------------------------------
module wnm_dp
    import wnm_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire cmd_t       cmd,
    output status_t         status,
    input  wire logic       mode,
    input  wire logic [7:0] character,
    input  wire logic       has_char,
    input  wire logic       last,
    output logic            result_valid,
    input  wire logic       result_stall,
    output logic            matched,
    output logic            overflow
);

    localparam int LEN_W = $clog2(MAX_LEN + 1);
    localparam int IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_LEN);

    logic [7:0] pmem [MAX_LEN];
    logic [7:0] nmem [MAX_LEN];

    logic [LEN_W-1:0] plen_reg, plen_next;
    logic [LEN_W-1:0] nlen_reg, nlen_next;
    logic             povf_reg, povf_next;
    logic             novf_reg, novf_next;
    logic             pclosed_reg, pclosed_next;
    logic             nclosed_reg, nclosed_next;

    logic [LEN_W-1:0] p_reg, p_next;
    logic [LEN_W-1:0] n_reg, n_next;
    logic [LEN_W-1:0] star_reg, star_next;
    logic [LEN_W-1:0] resume_reg, resume_next;
    logic             have_star_reg, have_star_next;

    logic [7:0] pc_reg;
    logic [7:0] nc_reg;

    logic res_match_reg;
    logic res_ovf_reg;
    logic result_valid_reg;
    logic matched_reg;
    logic overflow_reg;

    logic [LEN_W-1:0] p_eff_len;
    logic [LEN_W-1:0] n_eff_len;
    logic             p_wr;
    logic             n_wr;
    logic             p_lt;
    logic             hit_one;
    logic             hit_run;

    // request intake
    always_comb
    begin
        p_eff_len    = pclosed_reg ? '0 : plen_reg;
        n_eff_len    = nclosed_reg ? '0 : nlen_reg;
        plen_next    = plen_reg;
        nlen_next    = nlen_reg;
        povf_next    = povf_reg;
        novf_next    = novf_reg;
        pclosed_next = pclosed_reg;
        nclosed_next = nclosed_reg;
        p_wr         = 1'b0;
        n_wr         = 1'b0;
        if (cmd.load)
        begin
            if (!mode)
            begin
                plen_next    = p_eff_len;
                povf_next    = pclosed_reg ? 1'b0 : povf_reg;
                pclosed_next = last;
                if (has_char)
                begin
                    if (p_eff_len < LEN_MAX)
                    begin
                        p_wr      = 1'b1;
                        plen_next = p_eff_len + 1'b1;
                    end
                    else
                    begin
                        povf_next = 1'b1;
                    end
                end
            end
            else
            begin
                nlen_next    = n_eff_len;
                novf_next    = nclosed_reg ? 1'b0 : novf_reg;
                nclosed_next = last;
                if (has_char)
                begin
                    if (n_eff_len < LEN_MAX)
                    begin
                        n_wr      = 1'b1;
                        nlen_next = n_eff_len + 1'b1;
                    end
                    else
                    begin
                        novf_next = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (p_wr)
        begin
            pmem[p_eff_len[IDX_W-1:0]] <= character;
        end
        if (n_wr)
        begin
            nmem[n_eff_len[IDX_W-1:0]] <= character;
        end
        if (cmd.fetch)
        begin
            pc_reg <= pmem[p_reg[IDX_W-1:0]];
            nc_reg <= nmem[n_reg[IDX_W-1:0]];
        end
    end

    // match walk
    assign p_lt    = p_reg < plen_reg;
    assign hit_one = p_lt && ((pc_reg == ANY_ONE) || (pc_reg == nc_reg));
    assign hit_run = p_lt && (pc_reg == ANY_RUN);

    always_comb
    begin
        p_next         = p_reg;
        n_next         = n_reg;
        star_next      = star_reg;
        resume_next    = resume_reg;
        have_star_next = have_star_reg;
        if (cmd.init)
        begin
            p_next         = '0;
            n_next         = '0;
            have_star_next = 1'b0;
        end
        else if (cmd.scan_step)
        begin
            if (hit_one)
            begin
                p_next = p_reg + 1'b1;
                n_next = n_reg + 1'b1;
            end
            else if (hit_run)
            begin
                have_star_next = 1'b1;
                star_next      = p_reg;
                resume_next    = n_reg;
                p_next         = p_reg + 1'b1;
            end
            else
            begin
                p_next      = star_reg + 1'b1;
                resume_next = resume_reg + 1'b1;
                n_next      = resume_reg + 1'b1;
            end
        end
        else if (cmd.tail_step)
        begin
            p_next = p_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plen_reg         <= '0;
            nlen_reg         <= '0;
            povf_reg         <= 1'b0;
            novf_reg         <= 1'b0;
            pclosed_reg      <= 1'b1;
            nclosed_reg      <= 1'b1;
            p_reg            <= '0;
            n_reg            <= '0;
            star_reg         <= '0;
            resume_reg       <= '0;
            have_star_reg    <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            plen_reg      <= plen_next;
            nlen_reg      <= nlen_next;
            povf_reg      <= povf_next;
            novf_reg      <= novf_next;
            pclosed_reg   <= pclosed_next;
            nclosed_reg   <= nclosed_next;
            p_reg         <= p_next;
            n_reg         <= n_next;
            star_reg      <= star_next;
            resume_reg    <= resume_next;
            have_star_reg <= have_star_next;
            if (cmd.out_load)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // result
    always_ff @(posedge clk)
    begin
        if (cmd.res_set)
        begin
            res_match_reg <= cmd.res_match;
            res_ovf_reg   <= cmd.res_ovf;
        end
        if (cmd.out_load)
        begin
            matched_reg  <= res_match_reg;
            overflow_reg <= res_ovf_reg;
        end
    end

    assign status.ovf       = povf_reg || novf_reg;
    assign status.n_done    = n_reg >= nlen_reg;
    assign status.p_done    = !p_lt;
    assign status.scan_fail = !hit_one && !hit_run && !have_star_reg;
    assign status.tail_star = pc_reg == ANY_RUN;
    assign status.out_free  = !result_valid_reg || !result_stall;

    assign result_valid = result_valid_reg;
    assign matched      = matched_reg;
    assign overflow     = overflow_reg;

endmodule
`default_nettype wire

### tb/wildcard_name_matcher_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wildcard_name_matcher_test
// Streams glob patterns and names into the matcher and checks each verdict
// against a local glob predictor, or against the listed verdict for typed rows
// of the short directed table, which comes first. Then random patterns, names
// built to fit them, open and interleaved strings and over-long strings follow, under several idle and stall mixes.
// ----------------------------------------------------------------------------
module wildcard_name_matcher_test;
    import wnm_pkg::*;

    localparam int MAX_LEN = MAX_LEN_DEF;
    localparam logic MODE_PATTERN = 1'b0;
    localparam logic MODE_NAME = 1'b1;
    localparam int TOTAL_REQS = 1900;
    localparam int DIR_ROWS = 24;
    localparam int HOLD_CYCLES = 400;
    localparam int END_WAIT = 64;
    localparam int SHOW_MAX = 10;
    localparam int TIMEOUT_NS = 100_000_000;

    typedef struct packed {
        logic       mode;
        logic [7:0] ch;
        logic       has;
        logic       last;
    } req_t;

    typedef struct packed {
        logic hit;
        logic ovf;
    } verdict_t;

    typedef struct packed {
        req_t     req;
        logic     typed;
        verdict_t want;
    } dir_row_t;

    typedef logic [7:0] text_t [$];

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       item_valid = 1'b0;
    logic       item_stall;
    logic       mode = 1'b0;
    logic [7:0] character = 8'h00;
    logic       has_char = 1'b0;
    logic       last = 1'b0;
    logic       result_valid;
    logic       result_stall = 1'b0;
    logic       matched;
    logic       overflow;

    // predictor state
    logic [7:0] pat_store [MAX_LEN];
    int         pat_cnt = 0;
    logic       pat_over = 1'b0;
    logic       pat_done = 1'b1;
    logic [7:0] nm_store [MAX_LEN];
    int         nm_cnt = 0;
    logic       nm_over = 1'b0;
    logic       nm_done = 1'b1;

    verdict_t    verdict_q [$];
    dir_row_t    dir_rows [DIR_ROWS];
    int unsigned idle_pct = 0;
    int unsigned stall_pct = 0;
    logic        hold_go = 1'b0;
    logic        hold_seen = 1'b0;
    int unsigned hold_left = 0;
    int          n_sent = 0;
    int          n_results = 0;
    int          n_hits = 0;
    int          n_over = 0;
    int          bad = 0;

    wildcard_name_matcher dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .mode         (mode),
        .character    (character),
        .has_char     (has_char),
        .last         (last),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .matched      (matched),
        .overflow     (overflow)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // greedy star-backtracking scan over the predictor's strings
    function automatic logic glob_hit();
        int   p;
        int   n;
        int   star;
        int   resume;
        logic have_star;
        p = 0;
        n = 0;
        star = 0;
        resume = 0;
        have_star = 1'b0;
        while (n < nm_cnt)
        begin
            if (p < pat_cnt && (pat_store[p] == ANY_ONE || pat_store[p] == nm_store[n]))
            begin
                p++;
                n++;
            end
            else if (p < pat_cnt && pat_store[p] == ANY_RUN)
            begin
                have_star = 1'b1;
                star = p;
                resume = n;
                p++;
            end
            else if (have_star)
            begin
                p = star + 1;
                resume++;
                n = resume;
            end
            else
                return 1'b0;
        end
        while (p < pat_cnt && pat_store[p] == ANY_RUN)
            p++;
        return p == pat_cnt;
    endfunction

    task automatic apply_req(input req_t r, input logic typed, input verdict_t want);
        verdict_t v;
        if (r.mode == MODE_PATTERN)
        begin
            if (pat_done)
            begin
                pat_cnt = 0;
                pat_over = 1'b0;
                pat_done = 1'b0;
            end
            if (r.has)
            begin
                if (pat_cnt < MAX_LEN)
                begin
                    pat_store[pat_cnt] = r.ch;
                    pat_cnt++;
                end
                else
                    pat_over = 1'b1;
            end
            if (r.last)
                pat_done = 1'b1;
        end
        else
        begin
            if (nm_done)
            begin
                nm_cnt = 0;
                nm_over = 1'b0;
                nm_done = 1'b0;
            end
            if (r.has)
            begin
                if (nm_cnt < MAX_LEN)
                begin
                    nm_store[nm_cnt] = r.ch;
                    nm_cnt++;
                end
                else
                    nm_over = 1'b1;
            end
            if (r.last)
            begin
                nm_done = 1'b1;
                v.ovf = pat_over | nm_over;
                v.hit = !v.ovf && glob_hit();
                verdict_q = {verdict_q, (typed ? want : v)};
            end
        end
    endtask

    task automatic send_req(input req_t r, input logic typed, input verdict_t want);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        mode <= r.mode;
        character <= r.ch;
        has_char <= r.has;
        last <= r.last;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        n_sent++;
        apply_req(r, typed, want);
    endtask

    task automatic wait_verdicts_done();
        item_valid <= 1'b0;
        do
            @(posedge clk);
        while (verdict_q.size() != 0);
    endtask

    function automatic logic [7:0] rand_char(input logic wild);
        int unsigned pick;
        pick = $urandom_range(99);
        if (wild && pick < 15)
            return ANY_RUN;
        if (wild && pick < 30)
            return ANY_ONE;
        if (pick < 40)
            return 8'($urandom_range(255));
        return 8'(8'h61 + $urandom_range(2));
    endfunction

    function automatic text_t rand_text(input logic wild);
        text_t t;
        int    len;
        len = ($urandom_range(99) < 5) ? $urandom_range(34, 29) : $urandom_range(6);
        repeat (len)
            t = {t, rand_char(wild)};
        return t;
    endfunction

    // half the names are built from the stored pattern, some of them spoiled
    function automatic text_t name_text();
        text_t t;
        int    k;
        if ($urandom_range(1))
            return rand_text(1'b0);
        for (int i = 0; i < pat_cnt; i++)
        begin
            if (pat_store[i] == ANY_ONE)
                t = {t, rand_char(1'b0)};
            else if (pat_store[i] == ANY_RUN)
                repeat ($urandom_range(3))
                    t = {t, rand_char(1'b0)};
            else
                t = {t, pat_store[i]};
        end
        if (t.size() != 0 && $urandom_range(99) < 20)
        begin
            k = $urandom_range(t.size() - 1);
            if ($urandom_range(1))
                t[k] = t[k] ^ 8'h01;
            else
                t.delete(k);
        end
        return t;
    endfunction

    task automatic send_text(input logic m, input text_t chars, input logic close,
                             input int mix_at);
        req_t r;
        if (chars.size() == 0)
        begin
            r = '{m, 8'h00, 1'b0, close};
            send_req(r, 1'b0, '0);
            return;
        end
        foreach (chars[i])
        begin
            if (i == mix_at)
            begin
                r = '{MODE_PATTERN, rand_char(1'b1), 1'b1, 1'($urandom_range(1))};
                send_req(r, 1'b0, '0);
            end
            // empty filler, character ignored
            if ($urandom_range(99) < 3)
            begin
                r = '{m, 8'($urandom_range(255)), 1'b0, 1'b0};
                send_req(r, 1'b0, '0);
            end
            r = '{m, chars[i], 1'b1, close && (i == chars.size() - 1)};
            send_req(r, 1'b0, '0);
        end
    endtask

    // long receiver hold-off, counted here
    always @(posedge clk)
    begin
        if (hold_go != hold_seen)
        begin
            hold_seen = hold_go;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            result_stall <= 1'b1;
        end
        else
            result_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        verdict_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            n_results++;
            if (matched)
                n_hits++;
            if (overflow)
                n_over++;
            if (verdict_q.size() == 0)
            begin
                bad++;
                if (bad <= SHOW_MAX)
                    $display("unexpected verdict %0d: matched=%0b overflow=%0b",
                             n_results, matched, overflow);
            end
            else
            begin
                want = verdict_q.pop_front();
                if (matched !== want.hit || overflow !== want.ovf)
                begin
                    bad++;
                    if (bad <= SHOW_MAX)
                        $display("verdict %0d: matched/overflow expected %0b/%0b, got %0b/%0b",
                                 n_results, want.hit, want.ovf, matched, overflow);
                end
            end
        end
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("wildcard_name_matcher_test: timeout, %0d verdicts pending", verdict_q.size());
        $display("wildcard_name_matcher_test: done, errors");
        $finish;
    end

    initial
    begin
        int unsigned pick;
        int          phase_end;
        text_t       chars;
        dir_rows = '{
            // empty pattern after reset
            '{'{MODE_NAME,    8'h00,   1'b0, 1'b1}, 1'b1, '{1'b1, 1'b0}},
            '{'{MODE_NAME,    "a",     1'b1, 1'b1}, 1'b1, '{1'b0, 1'b0}},
            // lone star
            '{'{MODE_PATTERN, ANY_RUN, 1'b1, 1'b1}, 1'b0, '{1'b0, 1'b0}},
            '{'{MODE_NAME,    8'h00,   1'b0, 1'b1}, 1'b1, '{1'b1, 1'b0}},
            '{'{MODE_NAME,    8'hFF,   1'b1, 1'b1}, 1'b1, '{1'b1, 1'b0}},
            // a?c, then reused
            '{'{MODE_PATTERN, "a",     1'b1, 1'b0}, 1'b0, '{1'b0, 1'b0}},
            '{'{MODE_PATTERN, ANY_ONE, 1'b1, 1'b0}, 1'b0, '{1'b0, 1'b0}},
            '{'{MODE_PATTERN, "c",     1'b1, 1'b1}, 1'b0, '{1'b0, 1'b0}},
            '{'{MODE_NAME,    "a",     1'b1, 1'b0}, 1'b0, '{1'b0, 1'b0}},
            '{'{MODE_NAME,    "b",     1'b1, 1'b0}, 1'b0, '{1'b0, 1'b0}},
            '{'{MODE_NAME,    "c",     1'b1, 1'b1}, 1'b0, '{1'b0, 1'b0}},
            '{'{MODE_NAME,    "a",     1'b1, 1'b0}, 1'b0, '{1'b0, 1'b0}},
            '{'{MODE_NAME,    ANY_ONE, 1'b1, 1'b0}, 1'b0, '{1'b0, 1'b0}},
            '{'{MODE_NAME,    "c",     1'b1, 1'b1}, 1'b0, '{1'b0, 1'b0}},
            // byte extremes around a star
            '{'{MODE_PATTERN, 8'h00,   1'b1, 1'b0}, 1'b0, '{1'b0, 1'b0}},
            '{'{MODE_PATTERN, ANY_RUN, 1'b1, 1'b0}, 1'b0, '{1'b0, 1'b0}},
            '{'{MODE_PATTERN, 8'hFF,   1'b1, 1'b1}, 1'b0, '{1'b0, 1'b0}},
            '{'{MODE_NAME,    8'h00,   1'b1, 1'b0}, 1'b0, '{1'b0, 1'b0}},
            '{'{MODE_NAME,    8'h55,   1'b1, 1'b0}, 1'b0, '{1'b0, 1'b0}},
            '{'{MODE_NAME,    8'hAA,   1'b1, 1'b0}, 1'b0, '{1'b0, 1'b0}},
            '{'{MODE_NAME,    8'hFF,   1'b1, 1'b1}, 1'b0, '{1'b0, 1'b0}},
            // pattern left open during a name, closed empty
            '{'{MODE_PATTERN, "x",     1'b1, 1'b0}, 1'b0, '{1'b0, 1'b0}},
            '{'{MODE_NAME,    "x",     1'b1, 1'b1}, 1'b0, '{1'b0, 1'b0}},
            '{'{MODE_PATTERN, 8'h00,   1'b0, 1'b1}, 1'b0, '{1'b0, 1'b0}}
        };
        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (dir_rows[i])
            send_req(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);
        wait_verdicts_done();

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    idle_pct = 0;
                    stall_pct = 0;
                    hold_go = ~hold_go;
                end
                1:
                begin
                    idle_pct = 81;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct = 0;
                    stall_pct = 81;
                end
                default:
                begin
                    idle_pct = 34;
                    stall_pct = 34;
                end
            endcase
            phase_end = DIR_ROWS + (ph + 1) * (TOTAL_REQS - DIR_ROWS) / 4;
            while (n_sent < phase_end)
            begin
                pick = $urandom_range(99);
                if (pick < 12)
                    send_text(MODE_PATTERN, rand_text(1'b1), 1'b1, -1);
                else if (pick < 16)
                    send_text(MODE_PATTERN, rand_text(1'b1), 1'b0, -1);
                else if (pick < 21)
                begin
                    chars = name_text();
                    send_text(MODE_NAME, chars, 1'b1, $urandom_range(chars.size()));
                end
                else if (pick < 24)
                    send_text(MODE_NAME, rand_text(1'b0), 1'b0, -1);
                else
                    send_text(MODE_NAME, name_text(), 1'b1, -1);
            end
            wait_verdicts_done();
        end

        repeat (END_WAIT)
            @(posedge clk);
        $display("%0d requests sent, %0d verdicts checked (%0d matched, %0d overflow)",
                 n_sent, n_results, n_hits, n_over);
        $display("glob cases, open and interleaved strings, overflow, four idle/stall mixes");
        if (bad == 0)
            $display("wildcard_name_matcher_test: done, clean");
        else
            $display("wildcard_name_matcher_test: done, errors");
        $finish;
    end

endmodule
